// File: rtl/erafq_pkg.sv
// ============================================================================
// erafq_pkg
// Shared types, constants and helpers for the receive address filter queue.
// ============================================================================
package erafq_pkg;

    // Field widths
    localparam int MAC_W   = 48;
    localparam int ETYPE_W = 16;
    localparam int CLASS_W = 2;

    // Default queue depth
    localparam int DEF_QUEUE_DEPTH = 64;

    // Broadcast address: every byte all ones
    localparam logic [7:0]       BCAST_BYTE = 8'hFF;
    localparam logic [MAC_W-1:0] BCAST_MAC  = {6{BCAST_BYTE}};

    // EtherType codes
    localparam logic [ETYPE_W-1:0] ETYPE_ARP  = 16'h0806;
    localparam logic [ETYPE_W-1:0] ETYPE_IPV4 = 16'h0800;

    // Request opcodes
    typedef enum logic
    {
        OP_RECEIVE = 1'b0,
        OP_TAKE    = 1'b1
    } opcode_t;

    // Frame class codes
    typedef enum logic [CLASS_W-1:0]
    {
        CLASS_ARP   = 2'd0,
        CLASS_IPV4  = 2'd1,
        CLASS_OTHER = 2'd2
    } frame_class_t;

    // Queue control from the filter to the queue
    typedef struct packed
    {
        logic             push;
        logic             pop;
        logic [MAC_W-1:0] handle;
        frame_class_t     cls;
    } q_req_t;

    // Queue status back to the filter
    typedef struct packed
    {
        logic full;
        logic empty;
    } q_stat_t;

    // Map an EtherType to its frame class
    function automatic frame_class_t classify(input logic [ETYPE_W-1:0] etype);
        frame_class_t c;
        if (etype == ETYPE_ARP)
        begin
            c = CLASS_ARP;
        end
        else if (etype == ETYPE_IPV4)
        begin
            c = CLASS_IPV4;
        end
        else
        begin
            c = CLASS_OTHER;
        end
        return c;
    endfunction

endpackage

// File: rtl/erafq_queue.sv
// ============================================================================
// erafq_queue
// Frame handle FIFO: memory of handle and class, head/tail pointers, count.
// ============================================================================
module erafq_queue #(
    parameter int QUEUE_DEPTH = erafq_pkg::DEF_QUEUE_DEPTH,
    parameter int PTR_W       = $clog2(QUEUE_DEPTH),
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  erafq_pkg::q_req_t               req,
    output erafq_pkg::q_stat_t              stat,
    output logic [CNT_W-1:0]                count,
    output logic [erafq_pkg::MAC_W-1:0]     rd_handle,
    output erafq_pkg::frame_class_t         rd_class
);

    typedef struct packed
    {
        logic [erafq_pkg::MAC_W-1:0] handle;
        erafq_pkg::frame_class_t     cls;
    } entry_t;

    entry_t           mem [QUEUE_DEPTH];
    entry_t           rd_data_reg;
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Status from the count
    assign stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

    // Advance pointers with wrap, update count
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (req.push)
        begin
            tail_next  = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
        else if (req.pop)
        begin
            head_next  = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Write the tail entry on push
    always_ff @(posedge clk)
    begin
        if (req.push)
        begin
            mem[tail_reg] <= '{handle: req.handle, cls: req.cls};
        end
    end

    // Read the head entry on pop, hold otherwise
    always_ff @(posedge clk)
    begin
        if (req.pop)
        begin
            rd_data_reg <= mem[head_reg];
        end
    end

    assign count     = count_reg;
    assign rd_handle = rd_data_reg.handle;
    assign rd_class  = rd_data_reg.cls;

    // Count never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    // Push grows the count by one
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        req.push |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not grow count");

    // Pop only from a non-empty queue, and not together with push
    a_pop_legal: assert property (@(posedge clk) disable iff (!rst_n)
        req.pop |-> !stat.empty && !req.push)
        else $error("illegal pop");

endmodule

// File: rtl/ethernet_rx_address_filter_queue_unit.sv
// ============================================================================
// ethernet_rx_address_filter_queue_unit
// Destination MAC filter feeding a FIFO of frame handles with EtherType class.
// ============================================================================
// One request per clock: busy is never raised, so start may be held high every
// cycle. Each request gives exactly one result, shown with done high in the cycle
// after the request is taken; the receiver must capture it then.
// The taken handle and class come from the registered read of the queue memory. A
// receive request (opcode 0) is queued when dest_mac matches own_mac or is
// broadcast, flagged by dropped_full when the queue is full; a take request
// (opcode 1) pops the oldest handle and class, or returns take_valid low when
// empty. fill_level gives the queue count after the request. Write own_mac
// only while no result is pending.
module ethernet_rx_address_filter_queue_unit #(
    parameter int QUEUE_DEPTH = erafq_pkg::DEF_QUEUE_DEPTH,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration
    input  logic                            cfg_wr_en,
    input  logic [erafq_pkg::MAC_W-1:0]     cfg_wr_data,
    // Request
    input  logic                            start,
    output logic                            busy,
    input  logic                            opcode,
    input  logic [erafq_pkg::MAC_W-1:0]     frame_handle,
    input  logic [erafq_pkg::MAC_W-1:0]     dest_mac,
    input  logic [erafq_pkg::ETYPE_W-1:0]   ether_type,
    // Result
    output logic                            done,
    output logic                            accepted,
    output logic                            dropped_full,
    output logic                            take_valid,
    output logic [erafq_pkg::MAC_W-1:0]     out_handle,
    output logic [erafq_pkg::CLASS_W-1:0]   frame_class,
    output logic [CNT_W-1:0]                fill_level
);

    logic [erafq_pkg::MAC_W-1:0] own_mac_reg;
    erafq_pkg::q_req_t           q_req;
    erafq_pkg::q_stat_t          q_stat;
    logic [CNT_W-1:0]            q_count;
    logic [erafq_pkg::MAC_W-1:0] q_rd_handle;
    erafq_pkg::frame_class_t     q_rd_class;
    logic                        is_rx;
    logic                        is_take;
    logic                        addr_match;
    logic                        accepted_next;
    logic                        dropped_next;
    logic                        take_valid_next;
    logic                        done_reg;
    logic                        accepted_reg;
    logic                        dropped_reg;
    logic                        take_valid_reg;

    assign busy = 1'b0;

    // Hold the station address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            own_mac_reg <= cfg_wr_data;
        end
    end

    // Decode the request and filter the destination
    assign is_rx      = start && !busy && (opcode == erafq_pkg::OP_RECEIVE);
    assign is_take    = start && !busy && (opcode == erafq_pkg::OP_TAKE);
    assign addr_match = (dest_mac == own_mac_reg) || (dest_mac == erafq_pkg::BCAST_MAC);

    assign accepted_next   = is_rx && addr_match && !q_stat.full;
    assign dropped_next    = is_rx && addr_match && q_stat.full;
    assign take_valid_next = is_take && !q_stat.empty;

    // Drive the queue
    assign q_req.push   = accepted_next;
    assign q_req.pop    = take_valid_next;
    assign q_req.handle = frame_handle;
    assign q_req.cls    = erafq_pkg::classify(ether_type);

    erafq_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CNT_W       (CNT_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (q_req),
        .stat      (q_stat),
        .count     (q_count),
        .rd_handle (q_rd_handle),
        .rd_class  (q_rd_class)
    );

    // Register the result flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg       <= 1'b0;
            accepted_reg   <= 1'b0;
            dropped_reg    <= 1'b0;
            take_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg       <= start && !busy;
            accepted_reg   <= accepted_next;
            dropped_reg    <= dropped_next;
            take_valid_reg <= take_valid_next;
        end
    end

    // Present the result; zero the payload when nothing was taken
    assign done         = done_reg;
    assign accepted     = accepted_reg;
    assign dropped_full = dropped_reg;
    assign take_valid   = take_valid_reg;
    assign out_handle   = take_valid_reg ? q_rd_handle : '0;
    assign frame_class  = take_valid_reg ? q_rd_class : erafq_pkg::CLASS_ARP;
    assign fill_level   = q_count;

    // Every request yields a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> done)
        else $error("missing result");

    // Result flags only with a result and never together
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (accepted || dropped_full || take_valid) |->
            done && $onehot({accepted, dropped_full, take_valid}))
        else $error("result flags conflict");

    // A take result leaves the count one lower
    a_take_count: assert property (@(posedge clk) disable iff (!rst_n)
        take_valid_next |=> fill_level == $past(q_count) - 1'b1)
        else $error("take did not lower fill level");

endmodule

// File: verif/ethernet_rx_address_filter_queue_unit_test.sv
// ============================================================================
// ethernet_rx_address_filter_queue_unit_test
// Drives receive and take requests through the address filter queue, runs a
// local copy of the filter and frame queue, and checks every result field.
// ============================================================================
module ethernet_rx_address_filter_queue_unit_test;

    localparam int DEPTH          = erafq_pkg::DEF_QUEUE_DEPTH;
    localparam int CNT_W          = $clog2(DEPTH + 1);
    localparam int PTR_W          = $clog2(DEPTH);
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_ROWS       = 24;
    localparam int NUM_PHASES     = 5;
    localparam logic [erafq_pkg::MAC_W-1:0] ALL_ONES = '1;

    typedef struct packed
    {
        logic                        accepted;
        logic                        dropped;
        logic                        took;
        logic [erafq_pkg::MAC_W-1:0] handle;
        erafq_pkg::frame_class_t     cls;
        logic [CNT_W-1:0]            fill;
    } rx_result_t;

    typedef struct packed
    {
        erafq_pkg::opcode_t            op;
        logic [erafq_pkg::MAC_W-1:0]   handle;
        logic [erafq_pkg::MAC_W-1:0]   dest;
        logic [erafq_pkg::ETYPE_W-1:0] etype;
        logic                          typed;
        rx_result_t                    exp;
    } script_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_wr_en;
    logic [erafq_pkg::MAC_W-1:0]     cfg_wr_data;
    logic                            start;
    logic                            busy;
    logic                            opcode;
    logic [erafq_pkg::MAC_W-1:0]     frame_handle;
    logic [erafq_pkg::MAC_W-1:0]     dest_mac;
    logic [erafq_pkg::ETYPE_W-1:0]   ether_type;
    logic                            done;
    logic                            accepted;
    logic                            dropped_full;
    logic                            take_valid;
    logic [erafq_pkg::MAC_W-1:0]     out_handle;
    logic [erafq_pkg::CLASS_W-1:0]   frame_class;
    logic [CNT_W-1:0]                fill_level;

    // Typed expectation that travels with the request on the same edges
    logic                            row_typed;
    rx_result_t                      row_expect;

    // Local copy of the station address and the frame queue
    logic [erafq_pkg::MAC_W-1:0]     station_mac;
    logic [erafq_pkg::MAC_W-1:0]     q_handle [DEPTH];
    erafq_pkg::frame_class_t         q_class [DEPTH];
    logic [PTR_W-1:0]                q_head;
    logic [PTR_W-1:0]                q_tail;
    logic [CNT_W-1:0]                q_count;

    rx_result_t                      awaited_results[$];
    int                              mismatches;
    int                              idle_cycles;

    ethernet_rx_address_filter_queue_unit #(
        .QUEUE_DEPTH (DEPTH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .frame_handle (frame_handle),
        .dest_mac     (dest_mac),
        .ether_type   (ether_type),
        .done         (done),
        .accepted     (accepted),
        .dropped_full (dropped_full),
        .take_valid   (take_valid),
        .out_handle   (out_handle),
        .frame_class  (frame_class),
        .fill_level   (fill_level)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Filter one request and update the local frame queue
    function automatic rx_result_t filter_and_queue(
        input erafq_pkg::opcode_t            op,
        input logic [erafq_pkg::MAC_W-1:0]   handle,
        input logic [erafq_pkg::MAC_W-1:0]   dest,
        input logic [erafq_pkg::ETYPE_W-1:0] etype);
        rx_result_t r;
        r = '0;
        if (op == erafq_pkg::OP_RECEIVE)
        begin
            if (dest == station_mac || dest == erafq_pkg::BCAST_MAC)
            begin
                if (q_count < DEPTH)
                begin
                    q_handle[q_tail] = handle;
                    if (etype == erafq_pkg::ETYPE_ARP)
                    begin
                        q_class[q_tail] = erafq_pkg::CLASS_ARP;
                    end
                    else if (etype == erafq_pkg::ETYPE_IPV4)
                    begin
                        q_class[q_tail] = erafq_pkg::CLASS_IPV4;
                    end
                    else
                    begin
                        q_class[q_tail] = erafq_pkg::CLASS_OTHER;
                    end
                    q_tail     = (q_tail == PTR_W'(DEPTH - 1)) ? '0 : q_tail + 1'b1;
                    q_count    = q_count + 1'b1;
                    r.accepted = 1'b1;
                end
                else
                begin
                    r.dropped = 1'b1;
                end
            end
        end
        else if (q_count != 0)
        begin
            r.took   = 1'b1;
            r.handle = q_handle[q_head];
            r.cls    = q_class[q_head];
            q_head   = (q_head == PTR_W'(DEPTH - 1)) ? '0 : q_head + 1'b1;
            q_count  = q_count - 1'b1;
        end
        r.fill = q_count;
        return r;
    endfunction

    task automatic compare_field(input string name,
                                 input logic [erafq_pkg::MAC_W-1:0] want,
                                 input logic [erafq_pkg::MAC_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Check results, record expectations for accepted requests, watch for hangs
    always @(posedge clk)
    begin
        rx_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result with no request pending, expected none actual %0h",
                             $time, out_handle);
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    compare_field("accepted", want.accepted, accepted);
                    compare_field("dropped_full", want.dropped, dropped_full);
                    compare_field("take_valid", want.took, take_valid);
                    compare_field("out_handle", want.handle, out_handle);
                    compare_field("frame_class", want.cls, frame_class);
                    compare_field("fill_level", want.fill, fill_level);
                end
            end
            if (start && !busy)
            begin
                want = filter_and_queue(erafq_pkg::opcode_t'(opcode), frame_handle,
                                        dest_mac, ether_type);
                if (row_typed)
                begin
                    want = row_expect;
                end
                awaited_results.push_back(want);
            end
            if ((start && !busy) || done)
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("end of test: mismatches");
                    $finish;
                end
            end
        end
    end

    // Present one request and hold it until taken
    task automatic send_request(input script_row_t row);
        start        <= 1'b1;
        opcode       <= row.op;
        frame_handle <= row.handle;
        dest_mac     <= row.dest;
        ether_type   <= row.etype;
        row_typed    <= row.typed;
        row_expect   <= row.exp;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    // Idle after a request: mostly none or short, a few long, rarely a full drain
    task automatic idle_after(input bit quiet);
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        len  = 0;
        if (!quiet)
        begin
            if (pick >= 50 && pick < 85)
            begin
                len = $urandom_range(1, 3);
            end
            else if (pick >= 85 && pick < 97)
            begin
                len = $urandom_range(6, 25);
            end
            else if (pick >= 97)
            begin
                len = -1;
            end
        end
        if (len < 0)
        begin
            start <= 1'b0;
            @(posedge clk);
            while (awaited_results.size() != 0)
            begin
                @(posedge clk);
            end
        end
        else if (len > 0)
        begin
            start <= 1'b0;
            repeat (len) @(posedge clk);
        end
    endtask

    // Drain all requests, then write the station address
    task automatic set_station_mac(input logic [erafq_pkg::MAC_W-1:0] mac);
        start <= 1'b0;
        while (awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mac;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        station_mac  = mac;
    endtask

    function automatic script_row_t random_row(input int recv_pct);
        script_row_t r;
        int          pick;
        r        = '0;
        r.op     = ($urandom_range(0, 99) < recv_pct) ? erafq_pkg::OP_RECEIVE
                                                      : erafq_pkg::OP_TAKE;
        r.handle = {16'($urandom), 32'($urandom)};
        pick     = $urandom_range(0, 99);
        if (pick < 40)
        begin
            r.dest = station_mac;
        end
        else if (pick < 65)
        begin
            r.dest = erafq_pkg::BCAST_MAC;
        end
        else if (pick < 80)
        begin
            r.dest = station_mac ^ (48'h1 << $urandom_range(0, erafq_pkg::MAC_W - 1));
        end
        else
        begin
            r.dest = {16'($urandom), 32'($urandom)};
        end
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            r.etype = erafq_pkg::ETYPE_ARP;
        end
        else if (pick < 60)
        begin
            r.etype = erafq_pkg::ETYPE_IPV4;
        end
        else if (pick < 70)
        begin
            r.etype = ((pick & 1) ? erafq_pkg::ETYPE_ARP : erafq_pkg::ETYPE_IPV4)
                      ^ (16'h1 << $urandom_range(0, erafq_pkg::ETYPE_W - 1));
        end
        else
        begin
            r.etype = 16'($urandom);
        end
        return r;
    endfunction

    initial
    begin
        script_row_t                 script [NUM_ROWS];
        logic [erafq_pkg::MAC_W-1:0] phase_mac [NUM_PHASES];
        int                          phase_recv [NUM_PHASES];
        int                          phase_items [NUM_PHASES];
        bit                          phase_quiet [NUM_PHASES];

        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        start        = 1'b0;
        opcode       = erafq_pkg::OP_RECEIVE;
        frame_handle = '0;
        dest_mac     = '0;
        ether_type   = '0;
        row_typed    = 1'b0;
        row_expect   = '0;
        station_mac  = '0;
        q_head       = '0;
        q_tail       = '0;
        q_count      = '0;
        mismatches   = 0;
        idle_cycles  = 0;

        // Directed requests; the station address is zero out of reset
        script = '{
            '{erafq_pkg::OP_TAKE, 48'h0, 48'h0, 16'h0, 1'b1,
              '{1'b0, 1'b0, 1'b0, 48'h0, erafq_pkg::CLASS_ARP, 7'd0}},
            '{erafq_pkg::OP_RECEIVE, ALL_ONES, 48'h0, erafq_pkg::ETYPE_ARP, 1'b1,
              '{1'b1, 1'b0, 1'b0, 48'h0, erafq_pkg::CLASS_ARP, 7'd1}},
            '{erafq_pkg::OP_RECEIVE, 48'h0, erafq_pkg::BCAST_MAC, erafq_pkg::ETYPE_IPV4,
              1'b1, '{1'b1, 1'b0, 1'b0, 48'h0, erafq_pkg::CLASS_ARP, 7'd2}},
            '{erafq_pkg::OP_RECEIVE, 48'h1234_5678_9ABC, 48'h0000_0000_0001,
              erafq_pkg::ETYPE_IPV4, 1'b1,
              '{1'b0, 1'b0, 1'b0, 48'h0, erafq_pkg::CLASS_ARP, 7'd2}},
            '{erafq_pkg::OP_RECEIVE, 48'hA5A5_A5A5_A5A5, erafq_pkg::BCAST_MAC, 16'hFFFF,
              1'b1, '{1'b1, 1'b0, 1'b0, 48'h0, erafq_pkg::CLASS_ARP, 7'd3}},
            '{erafq_pkg::OP_RECEIVE, 48'h5A5A_5A5A_5A5A, 48'h0, 16'h0000, 1'b0, '0},
            '{erafq_pkg::OP_RECEIVE, 48'h1, 48'hFFFF_FFFF_FFFE, erafq_pkg::ETYPE_ARP, 1'b1,
              '{1'b0, 1'b0, 1'b0, 48'h0, erafq_pkg::CLASS_ARP, 7'd4}},
            '{erafq_pkg::OP_RECEIVE, 48'h2, 48'h7FFF_FFFF_FFFF, erafq_pkg::ETYPE_IPV4,
              1'b0, '0},
            '{erafq_pkg::OP_TAKE, 48'h0, 48'h0, 16'h0, 1'b1,
              '{1'b0, 1'b0, 1'b1, ALL_ONES, erafq_pkg::CLASS_ARP, 7'd3}},
            '{erafq_pkg::OP_TAKE, ALL_ONES, ALL_ONES, 16'hFFFF, 1'b1,
              '{1'b0, 1'b0, 1'b1, 48'h0, erafq_pkg::CLASS_IPV4, 7'd2}},
            '{erafq_pkg::OP_TAKE, 48'h0, 48'h0, 16'h0, 1'b1,
              '{1'b0, 1'b0, 1'b1, 48'hA5A5_A5A5_A5A5, erafq_pkg::CLASS_OTHER, 7'd1}},
            '{erafq_pkg::OP_TAKE, 48'h0, 48'h0, 16'h0, 1'b0, '0},
            '{erafq_pkg::OP_TAKE, ALL_ONES, ALL_ONES, 16'hFFFF, 1'b1,
              '{1'b0, 1'b0, 1'b0, 48'h0, erafq_pkg::CLASS_ARP, 7'd0}},
            '{erafq_pkg::OP_RECEIVE, 48'h8000_0000_0000, 48'h0, 16'h0807, 1'b0, '0},
            '{erafq_pkg::OP_RECEIVE, 48'h0000_FFFF_0000, erafq_pkg::BCAST_MAC, 16'h0801,
              1'b0, '0},
            '{erafq_pkg::OP_RECEIVE, 48'hFFFF_0000_FFFF, 48'h0, 16'h8806, 1'b0, '0},
            '{erafq_pkg::OP_RECEIVE, 48'h0123_4567_89AB, 48'h0, erafq_pkg::ETYPE_IPV4,
              1'b0, '0},
            '{erafq_pkg::OP_RECEIVE, 48'hFEDC_BA98_7654, erafq_pkg::BCAST_MAC,
              erafq_pkg::ETYPE_ARP, 1'b0, '0},
            '{erafq_pkg::OP_TAKE, 48'h0, 48'h0, 16'h0, 1'b0, '0},
            '{erafq_pkg::OP_TAKE, 48'h0, 48'h0, 16'h0, 1'b0, '0},
            '{erafq_pkg::OP_TAKE, 48'h0, 48'h0, 16'h0, 1'b0, '0},
            '{erafq_pkg::OP_TAKE, 48'h0, 48'h0, 16'h0, 1'b0, '0},
            '{erafq_pkg::OP_TAKE, 48'h0, 48'h0, 16'h0, 1'b0, '0},
            '{erafq_pkg::OP_TAKE, 48'h0, 48'h0, 16'h0, 1'b1,
              '{1'b0, 1'b0, 1'b0, 48'h0, erafq_pkg::CLASS_ARP, 7'd0}}
        };

        // Random phases: fill to full, hold full, drain, mix, drain empty
        phase_mac   = '{ALL_ONES, {16'($urandom), 32'($urandom)}, 48'h0000_0000_0001,
                        48'h8000_0000_0000, 48'h0};
        phase_recv  = '{85, 70, 25, 50, 15};
        phase_items = '{170, 140, 140, 130, 110};
        phase_quiet = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            send_request(script[i]);
            idle_after(1'b0);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_station_mac(phase_mac[p]);
            for (int n = 0; n < phase_items[p]; n++)
            begin
                send_request(random_row(phase_recv[p]));
                idle_after(phase_quiet[p] && n < phase_items[p] / 2);
            end
        end

        // Wait out the remaining results plus the pipeline
        start <= 1'b0;
        while (awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
